>>> sv/modular_add_sub_mul_unit_top_defines.svh
// Assertion macros shared by the modular add, subtract and multiply unit.
`ifndef MODULAR_ADD_SUB_MUL_UNIT_TOP_DEFINES_SVH
`define MODULAR_ADD_SUB_MUL_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MASMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MASMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/masmu_pkg.sv
// Types and constants of the modular add, subtract and multiply unit.
`timescale 1ns / 1ps

package masmu_pkg;

  localparam int unsigned OPERAND_WIDTH   = 31;
  localparam int unsigned OPCODE_WIDTH    = 2;
  localparam int unsigned STEPS_PER_STAGE = 2;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  typedef struct packed {
    logic neg;
    logic zero;
  } ctl_t;

endpackage

>>> sv/masmu_in_if.sv
// Input channel of the modular unit: opcode and two operands.
`timescale 1ns / 1ps

interface masmu_in_if #(
  parameter int unsigned Width = masmu_pkg::OPERAND_WIDTH
) ();
  import masmu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OPCODE_WIDTH-1:0] opcode;
  logic [Width-1:0]        operand_a;
  logic [Width-1:0]        operand_b;

  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

>>> sv/masmu_out_if.sv
// Output channel of the modular unit: one residue per transaction.
`timescale 1ns / 1ps

interface masmu_out_if #(
  parameter int unsigned Width = masmu_pkg::OPERAND_WIDTH
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] residue;

  modport source (output valid, residue, input ready);
  modport sink (input valid, residue, output ready);
endinterface

>>> sv/modular_add_sub_mul_unit_top.sv
// Top level of the modular add, subtract and multiply unit.
`timescale 1ns / 1ps
`include "modular_add_sub_mul_unit_top_defines.svh"

// Returns (a + b), (a - b) or (a * b) modulo the modulus register, with true
// modular subtraction, and zero for the unused opcode or a zero modulus. One
// transaction is accepted every cycle while the input is ready. The front
// register holds the full-width sum, difference magnitude or product, the
// remainder pipeline retires two dividend bits per stage over OPERAND_WIDTH
// stages, and the sign correction is applied as the output register loads.
// Stalls collapse bubbles, so the input stays ready until every stage is full.
// The modulus must only be written while no transaction is in flight.
module modular_add_sub_mul_unit_top #(
  parameter int unsigned OPERAND_WIDTH = masmu_pkg::OPERAND_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [OPERAND_WIDTH-1:0] cfg_wdata_i,
  masmu_in_if.sink                 in_if,
  masmu_out_if.source              out_if
);
  import masmu_pkg::*;

  localparam int unsigned ProdWidth = 2 * OPERAND_WIDTH;

  logic [OPERAND_WIDTH-1:0] modulus_q;

  logic                     f_v_q;
  ctl_t                     f_ctl_q;
  ctl_t                     f_ctl_d;
  logic [ProdWidth-1:0]     f_div_q;
  logic [ProdWidth-1:0]     f_div_d;
  logic                     f_ready;

  logic                     red_ready;
  logic                     red_valid;
  ctl_t                     red_ctl;
  logic [OPERAND_WIDTH-1:0] red_rem;

  logic                     o_v_q;
  logic [OPERAND_WIDTH-1:0] o_res_q;
  logic [OPERAND_WIDTH-1:0] o_res_d;
  logic                     o_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= OPERAND_WIDTH'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    f_ctl_d.neg  = 1'b0;
    f_ctl_d.zero = 1'b0;
    f_div_d      = '0;
    unique case (in_if.opcode)
      OP_ADD: begin
        f_div_d = ProdWidth'(in_if.operand_a) + ProdWidth'(in_if.operand_b);
      end
      OP_SUB: begin
        if (in_if.operand_a >= in_if.operand_b) begin
          f_div_d = ProdWidth'(in_if.operand_a - in_if.operand_b);
        end else begin
          f_div_d     = ProdWidth'(in_if.operand_b - in_if.operand_a);
          f_ctl_d.neg = 1'b1;
        end
      end
      OP_MUL: begin
        f_div_d = ProdWidth'(in_if.operand_a) * ProdWidth'(in_if.operand_b);
      end
      default: begin
        f_ctl_d.zero = 1'b1;
      end
    endcase
  end

  assign f_ready     = !f_v_q || red_ready;
  assign in_if.ready = f_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (f_ready) begin
      f_v_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && in_if.valid) begin
      f_ctl_q <= f_ctl_d;
      f_div_q <= f_div_d;
    end
  end

  masmu_reduce #(
    .Width         (OPERAND_WIDTH),
    .StepsPerStage (STEPS_PER_STAGE)
  ) u_reduce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .modulus_i     (modulus_q),
    .up_valid_i    (f_v_q),
    .up_ready_o    (red_ready),
    .up_ctl_i      (f_ctl_q),
    .up_dividend_i (f_div_q),
    .dn_valid_o    (red_valid),
    .dn_ready_i    (o_ready),
    .dn_ctl_o      (red_ctl),
    .dn_rem_o      (red_rem)
  );

  always_comb begin
    if (red_ctl.zero || (modulus_q == '0)) begin
      o_res_d = '0;
    end else if (red_ctl.neg && (red_rem != '0)) begin
      o_res_d = modulus_q - red_rem;
    end else begin
      o_res_d = red_rem;
    end
  end

  assign o_ready = !o_v_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_ready) begin
      o_v_q <= red_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && red_valid) begin
      o_res_q <= o_res_d;
    end
  end

  assign out_if.valid   = o_v_q;
  assign out_if.residue = o_res_q;

  `MASMU_ASSERT_NOW(a_backpressure_only_when_full, !in_if.ready,
    out_if.valid && !out_if.ready, "input stalled while the output could drain")
  `MASMU_ASSERT_NOW(a_front_waits_on_pipe, f_v_q && !red_ready,
    o_v_q && !out_if.ready, "front stage stalled with room downstream")
  `MASMU_ASSERT_NEXT(a_modulus_write, cfg_we_i,
    modulus_q == $past(cfg_wdata_i), "modulus register missed a write")

endmodule

>>> sv/masmu_reduce.sv
// Pipelined restoring remainder of a double-width dividend by the modulus.
`timescale 1ns / 1ps

module masmu_reduce #(
  parameter int unsigned Width         = masmu_pkg::OPERAND_WIDTH,
  parameter int unsigned StepsPerStage = masmu_pkg::STEPS_PER_STAGE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [Width-1:0]   modulus_i,
  input  logic               up_valid_i,
  output logic               up_ready_o,
  input  masmu_pkg::ctl_t    up_ctl_i,
  input  logic [2*Width-1:0] up_dividend_i,
  output logic               dn_valid_o,
  input  logic               dn_ready_i,
  output masmu_pkg::ctl_t    dn_ctl_o,
  output logic [Width-1:0]   dn_rem_o
);
  import masmu_pkg::*;

  localparam int unsigned DivWidth  = 2 * Width;
  localparam int unsigned NumStages = (DivWidth + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned PadWidth  = NumStages * StepsPerStage;

  logic                v_q     [NumStages];
  ctl_t                ctl_q   [NumStages];
  logic [Width-1:0]    rem_q   [NumStages];
  logic [PadWidth-1:0] div_q   [NumStages];

  logic                st_v    [NumStages];
  ctl_t                st_ctl  [NumStages];
  logic [Width-1:0]    st_rem  [NumStages];
  logic [PadWidth-1:0] st_div  [NumStages];
  logic [Width-1:0]    rem_d   [NumStages];
  logic [PadWidth-1:0] div_d   [NumStages];
  logic [NumStages:0]  rdy;

  always_comb begin
    st_v[0]   = up_valid_i;
    st_ctl[0] = up_ctl_i;
    st_rem[0] = '0;
    st_div[0] = PadWidth'(up_dividend_i);
    for (int k = 1; k < NumStages; k++) begin
      st_v[k]   = v_q[k-1];
      st_ctl[k] = ctl_q[k-1];
      st_rem[k] = rem_q[k-1];
      st_div[k] = div_q[k-1];
    end
  end

  always_comb begin : step_comb
    logic [Width:0]   trial;
    logic [Width-1:0] r;
    trial = '0;
    r     = '0;
    for (int k = 0; k < NumStages; k++) begin
      r = st_rem[k];
      for (int j = 0; j < StepsPerStage; j++) begin
        trial = {r, st_div[k][PadWidth-1-j]};
        if (trial >= {1'b0, modulus_i}) begin
          trial = trial - {1'b0, modulus_i};
        end
        r = trial[Width-1:0];
      end
      rem_d[k] = r;
      div_d[k] = st_div[k] << StepsPerStage;
    end
  end

  always_comb begin
    rdy[NumStages] = dn_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= st_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (rdy[k] && st_v[k]) begin
        ctl_q[k] <= st_ctl[k];
        rem_q[k] <= rem_d[k];
        div_q[k] <= div_d[k];
      end
    end
  end

  assign up_ready_o = rdy[0];
  assign dn_valid_o = v_q[NumStages-1];
  assign dn_ctl_o   = ctl_q[NumStages-1];
  assign dn_rem_o   = rem_q[NumStages-1];

endmodule

>>> test/modular_add_sub_mul_unit_top_tb.sv
// Self-checking testbench for the modular add, subtract and multiply unit.
`timescale 1ns / 1ps

module modular_add_sub_mul_unit_top_tb;
  import masmu_pkg::*;

  localparam logic [OPCODE_WIDTH-1:0] OP_RESERVED = 2'd3;
  localparam logic [OPERAND_WIDTH-1:0] ALL_ONES = {OPERAND_WIDTH{1'b1}};
  localparam logic [OPERAND_WIDTH-1:0] ALL_ONES_M1 = ALL_ONES - OPERAND_WIDTH'(1);
  localparam int unsigned PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 163;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  class residue_scoreboard;
    logic [OPERAND_WIDTH-1:0] modulus;
    logic [OPERAND_WIDTH-1:0] residue_q[$];
    int unsigned failures;

    function new();
      modulus = OPERAND_WIDTH'(1);
      failures = 0;
    endfunction

    function void set_modulus(logic [OPERAND_WIDTH-1:0] m);
      modulus = m;
    endfunction

    function logic [OPERAND_WIDTH-1:0] predict_residue(logic [OPCODE_WIDTH-1:0] op,
                                                       logic [OPERAND_WIDTH-1:0] a,
                                                       logic [OPERAND_WIDTH-1:0] b);
      logic [63:0] m;
      logic [63:0] r;
      m = 64'(modulus);
      r = 64'd0;
      if (m != 64'd0) begin
        case (op)
          OP_ADD: r = (64'(a) + 64'(b)) % m;
          OP_SUB: r = ((64'(a) % m) + m - (64'(b) % m)) % m;
          OP_MUL: r = (64'(a) * 64'(b)) % m;
          default: r = 64'd0;
        endcase
      end
      return r[OPERAND_WIDTH-1:0];
    endfunction

    function void note_operation(logic [OPCODE_WIDTH-1:0] op,
                                 logic [OPERAND_WIDTH-1:0] a,
                                 logic [OPERAND_WIDTH-1:0] b);
      residue_q.push_back(predict_residue(op, a, b));
    endfunction

    function void check_residue(logic [OPERAND_WIDTH-1:0] actual);
      logic [OPERAND_WIDTH-1:0] want;
      if (residue_q.size() == 0) begin
        $display("%0t: unexpected residue, expected none, actual %0d", $time, actual);
        failures++;
      end else begin
        want = residue_q.pop_front();
        if (actual !== want) begin
          $display("%0t: residue mismatch, expected %0d, actual %0d", $time, want, actual);
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return residue_q.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [OPERAND_WIDTH-1:0] cfg_wdata_i;
  bit                       hold_off_req;
  bit                       tail_quiet;

  residue_scoreboard sb = new();

  masmu_in_if  in_ch ();
  masmu_out_if out_ch ();

  modular_add_sub_mul_unit_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        sb.note_operation(in_ch.opcode, in_ch.operand_a, in_ch.operand_b);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_residue(out_ch.residue);
      end
    end
  end

  // The receiver alternates runs of readiness with short stalls, and serves one long
  // hold-off on request so that the pipeline fills and back-pressures the input.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      repeat ($urandom_range(0, 40)) begin
        @(negedge clk_i);
        if (hold_off_req) break;
      end
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (!tail_quiet) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end
    end
  end

  task automatic send_operation(input logic [OPCODE_WIDTH-1:0] op,
                                input logic [OPERAND_WIDTH-1:0] a,
                                input logic [OPERAND_WIDTH-1:0] b);
    @(negedge clk_i);
    in_ch.valid     = 1'b1;
    in_ch.opcode    = op;
    in_ch.operand_a = a;
    in_ch.operand_b = b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // The modulus is only changed once every transaction in flight has come out.
  task automatic write_modulus(input logic [OPERAND_WIDTH-1:0] m);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    cfg_wdata_i = m;
    cfg_we_i    = 1'b1;
    sb.set_modulus(m);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [OPERAND_WIDTH-1:0] pick_operand(logic [OPERAND_WIDTH-1:0] m);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = ($urandom_range(0, 1) != 0) ? 64'(ALL_ONES) : 64'd0;
      1: v = 64'($urandom_range(0, 1000));
      2: v = 64'(m) * $urandom_range(0, 3) + $urandom_range(0, 2) - 64'd1;
      3: v = 64'(m) - $urandom_range(0, 3);
      default: v = 64'($urandom);
    endcase
    return v[OPERAND_WIDTH-1:0];
  endfunction

  function automatic logic [OPCODE_WIDTH-1:0] pick_opcode();
    if ($urandom_range(0, 15) == 0) return OP_RESERVED;
    return OPCODE_WIDTH'($urandom_range(0, 2));
  endfunction

  function automatic logic [OPERAND_WIDTH-1:0] pick_modulus(int unsigned phase);
    case (phase)
      0: return OPERAND_WIDTH'(1);
      1: return OPERAND_WIDTH'(2);
      2: return OPERAND_WIDTH'(3);
      3: return ALL_ONES;
      4: return '0;
      5: return OPERAND_WIDTH'(1 << 30);
      6: return OPERAND_WIDTH'($urandom_range(2, 1000));
      7: return OPERAND_WIDTH'($urandom_range(1 << 16, 1 << 20));
      default: return OPERAND_WIDTH'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
  endfunction

  initial begin
    logic [OPERAND_WIDTH-1:0] m;
    int unsigned idle_odds;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    hold_off_req    = 1'b0;
    tail_quiet      = 1'b0;
    rst_ni          = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset modulus of one: every result must be zero.
    send_operation(OP_ADD, ALL_ONES, ALL_ONES);
    send_operation(OP_MUL, ALL_ONES, ALL_ONES);
    send_operation(OP_SUB, '0, ALL_ONES);
    send_operation(OP_RESERVED, ALL_ONES, '0);

    write_modulus(ALL_ONES);
    send_operation(OP_ADD, ALL_ONES_M1, ALL_ONES_M1);
    send_operation(OP_ADD, '0, '0);
    send_operation(OP_SUB, '0, ALL_ONES);
    send_operation(OP_SUB, OPERAND_WIDTH'(5), OPERAND_WIDTH'(9));
    send_operation(OP_SUB, ALL_ONES_M1, '0);
    send_operation(OP_MUL, ALL_ONES, ALL_ONES);
    send_operation(OP_MUL, ALL_ONES_M1, ALL_ONES_M1);
    send_operation(OP_MUL, '0, ALL_ONES);
    send_operation(OP_RESERVED, ALL_ONES, ALL_ONES);
    send_operation(OP_ADD, ALL_ONES, OPERAND_WIDTH'(1));

    // A zero modulus gives zero for every opcode.
    write_modulus('0);
    send_operation(OP_ADD, ALL_ONES, OPERAND_WIDTH'(1));
    send_operation(OP_SUB, OPERAND_WIDTH'(1), OPERAND_WIDTH'(2));
    send_operation(OP_MUL, OPERAND_WIDTH'(3), OPERAND_WIDTH'(4));
    send_operation(OP_RESERVED, OPERAND_WIDTH'(7), OPERAND_WIDTH'(7));

    write_modulus(OPERAND_WIDTH'(2));
    send_operation(OP_ADD, OPERAND_WIDTH'(1), OPERAND_WIDTH'(1));
    send_operation(OP_SUB, '0, OPERAND_WIDTH'(1));
    send_operation(OP_MUL, ALL_ONES, ALL_ONES);
    send_operation(OP_SUB, ALL_ONES, ALL_ONES_M1);

    for (int unsigned p = 0; p < PHASES; p++) begin
      m = pick_modulus(p);
      write_modulus(m);
      if (p == PHASES - 1) tail_quiet = 1'b1;
      idle_odds = $urandom_range(0, 8);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == 40) hold_off_req = 1'b1;
        if (!tail_quiet && !hold_off_req && idle_odds != 0 &&
            $urandom_range(1, 12) <= idle_odds) begin
          idle_sender($urandom_range(1, 15));
        end
        send_operation(pick_opcode(), pick_operand(m), pick_operand(m));
      end
    end

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (OPERAND_WIDTH + 4) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> modular_add_sub_mul_unit_top.f
+incdir+sv
sv/masmu_pkg.sv
sv/masmu_in_if.sv
sv/masmu_out_if.sv
sv/masmu_reduce.sv
sv/modular_add_sub_mul_unit_top.sv
test/modular_add_sub_mul_unit_top_tb.sv
